@@ sv/pbfa_pkg.sv @@
// pbfa_pkg: shared widths, opcodes, register indexes and limits of the
// periodic bin force accumulator. No dependencies.
package pbfa_pkg;

	localparam int POS_W      = 24;
	localparam int FORCE_W    = 32;
	localparam int ACC_W      = 48;
	localparam int FRAME_W    = 16;
	localparam int BIN_W      = 12;
	localparam int DEPTH      = 4096;
	localparam int AXIS_BIN_W = 6;   // per-axis bin, up to 64 bins
	localparam int AXIS_DIV_W = 31;  // (p - low) * nbin
	localparam int LIN_W      = 18;  // linear index before the depth check
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;
	localparam int WORD_W     = 3 * ACC_W;

	localparam logic [FRAME_W-1:0] FRAME_MAX = '1;

	typedef enum logic [1:0] {
		OP_DEPOSIT = 2'd0,
		OP_END     = 2'd1,
		OP_READ    = 2'd2,
		OP_CLEAR   = 2'd3
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REGION_X = 3'd0,
		REG_REGION_Y = 3'd1,
		REG_REGION_Z = 3'd2,
		REG_BOX_X    = 3'd3,
		REG_BOX_Y    = 3'd4,
		REG_BOX_Z    = 3'd5
	} reg_idx_t;

endpackage

@@ sv/pbfa_if.sv @@
// pbfa_if: valid/ready channel interfaces for input items, results and
// register writes. Depends on pbfa_pkg.
interface pbfa_in_if import pbfa_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [1:0]                opcode;
	logic [POS_W-1:0]          pos_x;
	logic [POS_W-1:0]          pos_y;
	logic [POS_W-1:0]          pos_z;
	logic signed [FORCE_W-1:0] force_x;
	logic signed [FORCE_W-1:0] force_y;
	logic signed [FORCE_W-1:0] force_z;
	logic [BIN_W-1:0]          read_bin;
	modport source (output valid, opcode, pos_x, pos_y, pos_z, force_x, force_y,
		force_z, read_bin, input ready);
	modport sink (input valid, opcode, pos_x, pos_y, pos_z, force_x, force_y,
		force_z, read_bin, output ready);
endinterface

interface pbfa_out_if import pbfa_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      hit;
	logic [BIN_W-1:0]          bin_out;
	logic signed [FORCE_W-1:0] avg_x;
	logic signed [FORCE_W-1:0] avg_y;
	logic signed [FORCE_W-1:0] avg_z;
	logic [FRAME_W-1:0]        frames_seen;
	logic                      saturated;
	modport source (output valid, hit, bin_out, avg_x, avg_y, avg_z, frames_seen,
		saturated, input ready);
	modport sink (input valid, hit, bin_out, avg_x, avg_y, avg_z, frames_seen,
		saturated, output ready);
endinterface

interface pbfa_cfg_if import pbfa_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] wdata;
	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

@@ sv/periodic_bin_force_accumulator.sv @@
// periodic_bin_force_accumulator: top level; FSM, register file, bin store.
// Depends on pbfa_pkg, pbfa_if, pbfa_axis, pbfa_sdiv.
//
//  channel | dir | handshake       | payload
//  --------+-----+-----------------+-------------------------------------------
//  din     | in  | valid / ready   | opcode, pos_x/y/z, force_x/y/z, read_bin
//  dout    | out | valid / ready   | hit, bin_out, avg_x/y/z, frames_seen, saturated
//  cfg     | in  | valid / ready=1 | reg_index, wdata
//
// One transaction in flight. A deposit waits on the 31-bit serial bin
// divider per axis (axes run side by side); a read waits on the 48-bit
// serial average dividers; an end frame goes straight to FIN. Clear zeroes
// every store row, one row zeroed per cycle. After reset the same sweep
// runs before din.ready rises; cfg writes are taken anytime.
// A finished result sits in the output register while the next transaction
// is accepted; a result waits in FIN only if the previous one is still held.
module periodic_bin_force_accumulator import pbfa_pkg::*; #(
	parameter int NBIN_X = 16,
	parameter int NBIN_Y = 16,
	parameter int NBIN_Z = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	pbfa_in_if.sink    din,
	pbfa_out_if.source dout,
	pbfa_cfg_if.sink   cfg
);
	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_AXIS, ST_LIN, ST_DRD, ST_DADD,
		ST_RRD, ST_RDIV, ST_RWAIT, ST_FIN
	} state_t;

	localparam int AW = $clog2(DEPTH);

	state_t state_q;

	// configuration registers
	logic [2*POS_W-1:0] region_x_q, region_y_q, region_z_q;
	logic [POS_W-1:0]   box_x_q, box_y_q, box_z_q;

	// transaction context
	logic signed [FORCE_W-1:0] fx_q, fy_q, fz_q;
	logic [BIN_W-1:0]          rb_q;
	logic [LIN_W-1:0]          lin_q;
	logic [FRAME_W-1:0]        frame_q;
	logic [AW-1:0]             clr_addr_q;
	logic                      clr_op_q;
	logic                      neg_x_q, neg_y_q, neg_z_q;

	// result staging and output register
	logic                      res_hit_q, res_sat_q;
	logic [BIN_W-1:0]          res_bin_q;
	logic signed [FORCE_W-1:0] res_ax_q, res_ay_q, res_az_q;
	logic                      ov_q, o_hit_q, o_sat_q;
	logic [BIN_W-1:0]          o_bin_q;
	logic signed [FORCE_W-1:0] o_ax_q, o_ay_q, o_az_q;
	logic [FRAME_W-1:0]        o_frames_q;

	// bin store: {z, y, x} sums per row
	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;
	logic [AW-1:0]     rd_addr, wr_addr;
	logic              we;
	logic [WORD_W-1:0] wdata;

	// axis units
	logic                  ax_start, ax_done, ay_done, az_done;
	logic                  ax_in, ay_in, az_in;
	logic [AXIS_BIN_W-1:0] ix, iy, iz;
	logic [LIN_W-1:0]      lin_c;
	logic                  lin_hit_c;

	// accumulate path
	logic signed [ACC_W-1:0] nx_c, ny_c, nz_c;
	logic                    sx_c, sy_c, sz_c;

	// average path
	logic                    div_start;
	logic [ACC_W-1:0]        mx_c, my_c, mz_c, qx, qy, qz;
	logic                    dx_done, dy_done, dz_done;
	logic signed [FORCE_W-1:0] avx_c, avy_c, avz_c;
	logic                    asx_c, asy_c, asz_c;

	logic in_acc;

	function automatic logic signed [ACC_W:0] sat_add(
		input logic signed [ACC_W-1:0] acc,
		input logic signed [FORCE_W-1:0] add
	);
		logic signed [ACC_W:0] s;
		logic signed [ACC_W-1:0] r;
		s = {acc[ACC_W-1], acc} + (ACC_W+1)'(add);
		if (s[ACC_W] != s[ACC_W-1])
			r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		else
			r = s[ACC_W-1:0];
		return {s[ACC_W] != s[ACC_W-1], r};
	endfunction

	function automatic logic [ACC_W-1:0] mag(input logic signed [ACC_W-1:0] v);
		return v[ACC_W-1] ? ACC_W'(-v) : v;
	endfunction

	// clamp of |sum| / frames back to a signed 32-bit average; top bit = clamped
	function automatic logic [FORCE_W:0] clamp_avg(input logic neg, input logic [ACC_W-1:0] q);
		logic [ACC_W-1:0] lim;
		logic [FORCE_W-1:0] r;
		logic s;
		lim = neg ? ACC_W'(64'h8000_0000) : ACC_W'(64'h7FFF_FFFF);
		s   = q > lim;
		if (s)
			r = lim[FORCE_W-1:0];
		else
			r = neg ? FORCE_W'(-q[FORCE_W-1:0]) : q[FORCE_W-1:0];
		return {s, r};
	endfunction

	assign in_acc   = din.valid && din.ready;
	assign din.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign ax_start = in_acc && (din.opcode == OP_DEPOSIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_x_q <= '0;
			region_y_q <= '0;
			region_z_q <= '0;
			box_x_q    <= '0;
			box_y_q    <= '0;
			box_z_q    <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				REG_REGION_X: region_x_q <= cfg.wdata;
				REG_REGION_Y: region_y_q <= cfg.wdata;
				REG_REGION_Z: region_z_q <= cfg.wdata;
				REG_BOX_X:    box_x_q <= cfg.wdata[POS_W-1:0];
				REG_BOX_Y:    box_y_q <= cfg.wdata[POS_W-1:0];
				REG_BOX_Z:    box_z_q <= cfg.wdata[POS_W-1:0];
				default: ;
			endcase
		end
	end

	pbfa_axis #(.NBIN(NBIN_X)) u_ax (
		.clk(clk), .arst_n(arst_n), .start(ax_start), .pos(din.pos_x),
		.region(region_x_q), .box(box_x_q), .done(ax_done), .in_range(ax_in), .bin(ix)
	);
	pbfa_axis #(.NBIN(NBIN_Y)) u_ay (
		.clk(clk), .arst_n(arst_n), .start(ax_start), .pos(din.pos_y),
		.region(region_y_q), .box(box_y_q), .done(ay_done), .in_range(ay_in), .bin(iy)
	);
	pbfa_axis #(.NBIN(NBIN_Z)) u_az (
		.clk(clk), .arst_n(arst_n), .start(ax_start), .pos(din.pos_z),
		.region(region_z_q), .box(box_z_q), .done(az_done), .in_range(az_in), .bin(iz)
	);

	// linear index; grid products are elaboration constants
	assign lin_c = LIN_W'(ix) + LIN_W'(iy) * LIN_W'(NBIN_X)
		+ LIN_W'(iz) * LIN_W'(NBIN_X * NBIN_Y);
	assign lin_hit_c = ax_in && ay_in && az_in && (lin_c < LIN_W'(DEPTH));

	// store ports
	assign rd_addr = (state_q == ST_RRD) ? AW'(rb_q) : lin_q[AW-1:0];
	assign we      = (state_q == ST_CLEAR) || (state_q == ST_DADD);
	assign wr_addr = (state_q == ST_CLEAR) ? clr_addr_q : lin_q[AW-1:0];
	assign wdata   = (state_q == ST_CLEAR) ? '0 : {nz_c, ny_c, nx_c};

	always_ff @(posedge clk) begin
		if (we)
			mem[wr_addr] <= wdata;
		rdata_q <= mem[rd_addr];
	end

	assign {sx_c, nx_c} = sat_add(rdata_q[ACC_W-1:0], fx_q);
	assign {sy_c, ny_c} = sat_add(rdata_q[2*ACC_W-1:ACC_W], fy_q);
	assign {sz_c, nz_c} = sat_add(rdata_q[3*ACC_W-1:2*ACC_W], fz_q);

	// averages: magnitude divide, sign restored at the clamp
	assign div_start = (state_q == ST_RDIV) && (frame_q != '0);
	assign mx_c = mag(rdata_q[ACC_W-1:0]);
	assign my_c = mag(rdata_q[2*ACC_W-1:ACC_W]);
	assign mz_c = mag(rdata_q[3*ACC_W-1:2*ACC_W]);

	pbfa_sdiv #(.DW(ACC_W), .SW(FRAME_W)) u_dx (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(mx_c),
		.divisor(frame_q), .done(dx_done), .quot(qx)
	);
	pbfa_sdiv #(.DW(ACC_W), .SW(FRAME_W)) u_dy (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(my_c),
		.divisor(frame_q), .done(dy_done), .quot(qy)
	);
	pbfa_sdiv #(.DW(ACC_W), .SW(FRAME_W)) u_dz (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(mz_c),
		.divisor(frame_q), .done(dz_done), .quot(qz)
	);

	assign {asx_c, avx_c} = clamp_avg(neg_x_q, qx);
	assign {asy_c, avy_c} = clamp_avg(neg_y_q, qy);
	assign {asz_c, avz_c} = clamp_avg(neg_z_q, qz);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			clr_op_q   <= 1'b0;
			frame_q    <= '0;
			ov_q       <= 1'b0;
			fx_q       <= '0;
			fy_q       <= '0;
			fz_q       <= '0;
			rb_q       <= '0;
			lin_q      <= '0;
			neg_x_q    <= 1'b0;
			neg_y_q    <= 1'b0;
			neg_z_q    <= 1'b0;
			res_hit_q  <= 1'b0;
			res_sat_q  <= 1'b0;
			res_bin_q  <= '0;
			res_ax_q   <= '0;
			res_ay_q   <= '0;
			res_az_q   <= '0;
			o_hit_q    <= 1'b0;
			o_sat_q    <= 1'b0;
			o_bin_q    <= '0;
			o_ax_q     <= '0;
			o_ay_q     <= '0;
			o_az_q     <= '0;
			o_frames_q <= '0;
		end else begin
			// FIN reloads the output register whenever it is taken
			if (ov_q && dout.ready && (state_q != ST_FIN))
				ov_q <= 1'b0;

			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(DEPTH - 1))
						state_q <= clr_op_q ? ST_FIN : ST_IDLE;
				end
				ST_IDLE: begin
					if (in_acc) begin
						fx_q      <= din.force_x;
						fy_q      <= din.force_y;
						fz_q      <= din.force_z;
						rb_q      <= din.read_bin;
						res_hit_q <= 1'b0;
						res_sat_q <= (din.opcode == OP_END) && (frame_q == FRAME_MAX);
						res_bin_q <= (din.opcode == OP_READ) ? din.read_bin : '0;
						res_ax_q  <= '0;
						res_ay_q  <= '0;
						res_az_q  <= '0;
						unique case (din.opcode)
							OP_DEPOSIT: state_q <= ST_AXIS;
							OP_END: begin
								if (frame_q != FRAME_MAX)
									frame_q <= frame_q + FRAME_W'(1);
								state_q <= ST_FIN;
							end
							OP_READ: begin
								state_q   <= ST_RRD;
							end
							default: begin
								frame_q    <= '0;
								clr_op_q   <= 1'b1;
								clr_addr_q <= '0;
								state_q    <= ST_CLEAR;
							end
						endcase
					end
				end
				ST_AXIS: begin
					if (ax_done && ay_done && az_done)
						state_q <= ST_LIN;
				end
				ST_LIN: begin
					lin_q <= lin_c;
					state_q <= lin_hit_c ? ST_DRD : ST_FIN;
				end
				ST_DRD: state_q <= ST_DADD;
				ST_DADD: begin
					res_hit_q <= 1'b1;
					res_bin_q <= lin_q[BIN_W-1:0];
					res_sat_q <= sx_c || sy_c || sz_c;
					state_q   <= ST_FIN;
				end
				ST_RRD: state_q <= ST_RDIV;
				ST_RDIV: begin
					neg_x_q <= rdata_q[ACC_W-1];
					neg_y_q <= rdata_q[2*ACC_W-1];
					neg_z_q <= rdata_q[3*ACC_W-1];
					// no frames: averages stay zero
					state_q <= (frame_q == '0) ? ST_FIN : ST_RWAIT;
				end
				ST_RWAIT: begin
					if (dx_done && dy_done && dz_done) begin
						res_ax_q  <= avx_c;
						res_ay_q  <= avy_c;
						res_az_q  <= avz_c;
						res_sat_q <= asx_c || asy_c || asz_c;
						state_q   <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!ov_q || dout.ready) begin
						ov_q       <= 1'b1;
						o_hit_q    <= res_hit_q;
						o_sat_q    <= res_sat_q;
						o_bin_q    <= res_bin_q;
						o_ax_q     <= res_ax_q;
						o_ay_q     <= res_ay_q;
						o_az_q     <= res_az_q;
						o_frames_q <= frame_q;
						clr_op_q   <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign dout.valid       = ov_q;
	assign dout.hit         = o_hit_q;
	assign dout.bin_out     = o_bin_q;
	assign dout.avg_x       = o_ax_q;
	assign dout.avg_y       = o_ay_q;
	assign dout.avg_z       = o_az_q;
	assign dout.frames_seen = o_frames_q;
	assign dout.saturated   = o_sat_q;
endmodule

@@ sv/pbfa_sdiv.sv @@
// pbfa_sdiv: unsigned restoring divider, one quotient bit per cycle.
// No dependencies.
module pbfa_sdiv #(
	parameter int DW = 48,
	parameter int SW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [SW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quot
);
	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] acc_q;
	logic [SW-1:0] rem_q;
	logic [SW-1:0] dsr_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [SW:0]   trial;
	logic [SW:0]   diff;
	logic          ge;

	assign trial = {rem_q, acc_q[DW-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(DW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CW'(1);
			done_q <= (cnt_q == CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			acc_q <= {acc_q[DW-2:0], ge};
			rem_q <= ge ? diff[SW-1:0] : trial[SW-1:0];
		end
	end

	assign done = done_q;
	assign quot = acc_q;
endmodule

@@ sv/pbfa_axis.sv @@
// pbfa_axis: one axis: periodic wrap, region test and bin by serial divide.
// Depends on pbfa_pkg and pbfa_sdiv.
module pbfa_axis import pbfa_pkg::*; #(
	parameter int NBIN = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [POS_W-1:0]      pos,
	input  logic [2*POS_W-1:0]    region,
	input  logic [POS_W-1:0]      box,
	output logic                  done,
	output logic                  in_range,
	output logic [AXIS_BIN_W-1:0] bin
);
	localparam int PW = POS_W + 2;

	logic          v_s1, v_s2, v_s3, v_s4;
	logic [PW-1:0] low_s1, up_s1, len_s1, pos_s1;
	logic [PW-1:0] low_s2, up_s2, len_s2, p_s2;
	logic [PW-1:0] low_s3, up_s3, p_s3;
	logic          empty_s2, empty_s3, in_s4;
	logic [PW-1:0] low_c, upr_c, len_c, eff_up_c, sum_c, lowlen_c, diff_c, span_c;
	logic [AXIS_DIV_W-1:0] prod_c;
	logic [AXIS_DIV_W-1:0] quot;

	assign low_c    = PW'(region[POS_W-1:0]);
	assign upr_c    = PW'(region[2*POS_W-1:POS_W]);
	assign len_c    = PW'(box);
	assign eff_up_c = (upr_c > len_c || upr_c <= low_c) ? len_c : upr_c;
	assign sum_c    = pos_s1 + len_s1;
	assign lowlen_c = low_s2 + len_s2;
	assign diff_c   = p_s3 - low_s3;
	assign span_c   = up_s3 - low_s3;
	assign prod_c   = AXIS_DIV_W'(diff_c[POS_W-1:0]) * AXIS_DIV_W'(NBIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			low_s1 <= low_c;
			up_s1  <= eff_up_c;
			len_s1 <= len_c;
			pos_s1 <= PW'(pos);
		end
		if (v_s1) begin
			low_s2   <= low_s1;
			up_s2    <= up_s1;
			len_s2   <= len_s1;
			empty_s2 <= up_s1 <= low_s1;
			p_s2     <= (sum_c < up_s1) ? sum_c : pos_s1;
		end
		if (v_s2) begin
			low_s3   <= low_s2;
			up_s3    <= up_s2;
			empty_s3 <= empty_s2;
			// p - len >= low, kept unsigned
			p_s3     <= (p_s2 >= lowlen_c) ? p_s2 - len_s2 : p_s2;
		end
		if (v_s3) begin
			in_s4 <= !empty_s3 && p_s3 >= low_s3 && p_s3 < up_s3;
		end
	end

	// divider launched straight from stage three operands
	pbfa_sdiv #(.DW(AXIS_DIV_W), .SW(POS_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (v_s3),
		.dividend (prod_c),
		.divisor  (span_c[POS_W-1:0]),
		.done     (done),
		.quot     (quot)
	);

	assign in_range = in_s4 && !v_s4;
	assign bin      = quot[AXIS_BIN_W-1:0];
endmodule

@@ sv/pbfa_checker.sv @@
// pbfa_checker: port-level assertions on the top level, bound to it below.
// Depends on pbfa_pkg and periodic_bin_force_accumulator.
module pbfa_checker import pbfa_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic                      out_hit,
	input logic [BIN_W-1:0]          out_bin,
	input logic signed [FORCE_W-1:0] out_ax,
	input logic signed [FORCE_W-1:0] out_ay,
	input logic signed [FORCE_W-1:0] out_az
);
	// one transaction at a time: ready drops right after an accept
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a transaction is in flight");

	// deposit hits never carry averages
	a_hit_no_avg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_hit |-> out_ax == '0 && out_ay == '0 && out_az == '0)
		else $error("averages on a deposit result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_bin) && $stable(out_hit))
		else $error("result changed while stalled");
endmodule

bind periodic_bin_force_accumulator pbfa_checker u_pbfa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (din.valid),
	.in_ready  (din.ready),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.out_hit   (dout.hit),
	.out_bin   (dout.bin_out),
	.out_ax    (dout.avg_x),
	.out_ay    (dout.avg_y),
	.out_az    (dout.avg_z)
);
